// ----- sv/bsm_pkg.sv -----
// Package for the pipelined radix-2 Booth multiplier.
// Holds the Booth recoding codes and the fixed field widths.
// No dependencies.
package bsm_pkg;

    // Fixed widths of the operand fields and the product field
    localparam int FIELD_WIDTH   = 16;
    localparam int PRODUCT_WIDTH = 32;

    // Booth recoding of {multiplier low bit, previous bit}
    typedef enum logic [1:0] {
        BOOTH_HOLD_LO = 2'b00,
        BOOTH_ADD     = 2'b01,
        BOOTH_SUB     = 2'b10,
        BOOTH_HOLD_HI = 2'b11
    } booth_op_t;

endpackage

// ----- sv/bsm_stage.sv -----
// One Booth recoding step of the multiplier pipeline, with its own
// valid bit and stage register. Depends on bsm_pkg.
module bsm_stage #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_stall,
    input  logic [OPERAND_WIDTH:0]   up_acc,
    input  logic [OPERAND_WIDTH-1:0] up_mq,
    input  logic [OPERAND_WIDTH:0]   up_md,
    input  logic                     up_prev,
    output logic                     dn_valid,
    input  logic                     dn_stall,
    output logic [OPERAND_WIDTH:0]   dn_acc,
    output logic [OPERAND_WIDTH-1:0] dn_mq,
    output logic [OPERAND_WIDTH:0]   dn_md,
    output logic                     dn_prev
);
    import bsm_pkg::*;

    logic                     valid_reg;
    logic [OPERAND_WIDTH:0]   acc_reg;
    logic [OPERAND_WIDTH:0]   acc_next;
    logic [OPERAND_WIDTH-1:0] mq_reg;
    logic [OPERAND_WIDTH-1:0] mq_next;
    logic [OPERAND_WIDTH:0]   md_reg;
    logic                     prev_reg;
    logic [OPERAND_WIDTH:0]   sum;
    booth_op_t                op;
    logic                     load;

    // Hold while a valid item sits here and the next stage stalls
    assign up_stall = valid_reg && dn_stall;
    assign load     = !up_stall;

    // Add or subtract the multiplicand as the recoded bit pair asks
    always_comb
    begin
        op = booth_op_t'({up_mq[0], up_prev});
        case (op)
            BOOTH_ADD: sum = up_acc + up_md;
            BOOTH_SUB: sum = up_acc - up_md;
            default:   sum = up_acc;
        endcase
    end

    // Shift {acc, mq, prev} right arithmetically by one
    assign acc_next = {sum[OPERAND_WIDTH], sum[OPERAND_WIDTH:1]};
    assign mq_next  = {sum[0], up_mq[OPERAND_WIDTH-1:1]};

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= up_valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            acc_reg  <= acc_next;
            mq_reg   <= mq_next;
            md_reg   <= up_md;
            prev_reg <= up_mq[0];
        end
    end

    assign dn_valid = valid_reg;
    assign dn_acc   = acc_reg;
    assign dn_mq    = mq_reg;
    assign dn_md    = md_reg;
    assign dn_prev  = prev_reg;

endmodule

// ----- sv/booth_signed_multiplier.sv -----
// Signed radix-2 Booth multiplier, one pipeline stage per Booth step.
// An item (multiplicand, multiplier) may enter every clock cycle while nothing
// stalls; its product passes one stage per Booth step, each holding a single
// add/subtract of OPERAND_WIDTH+1 bits. A stall
// on the output holds only the stages that are occupied: empty stages fill,
// so the pipeline keeps taking items until every stage holds one.
// Top level; depends on bsm_pkg and bsm_stage.
module booth_signed_multiplier #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [bsm_pkg::FIELD_WIDTH-1:0] multiplicand_value,
    input  logic signed [bsm_pkg::FIELD_WIDTH-1:0] multiplier_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [bsm_pkg::PRODUCT_WIDTH-1:0] product_value
);
    import bsm_pkg::*;

    localparam int EXT_WIDTH  = (OPERAND_WIDTH > FIELD_WIDTH) ? OPERAND_WIDTH : FIELD_WIDTH;
    localparam int CAT_WIDTH  = 2 * OPERAND_WIDTH + 1;
    localparam int PEXT_WIDTH = (CAT_WIDTH > PRODUCT_WIDTH) ? CAT_WIDTH : PRODUCT_WIDTH;

    logic [EXT_WIDTH-1:0]     md_ext;
    logic [EXT_WIDTH-1:0]     mq_ext;
    logic [OPERAND_WIDTH-1:0] md_op;

    logic                     v   [OPERAND_WIDTH+1];
    logic                     st  [OPERAND_WIDTH+1];
    logic [OPERAND_WIDTH:0]   acc [OPERAND_WIDTH+1];
    logic [OPERAND_WIDTH-1:0] mq  [OPERAND_WIDTH+1];
    logic [OPERAND_WIDTH:0]   md  [OPERAND_WIDTH+1];
    logic                     pv  [OPERAND_WIDTH+1];

    logic signed [CAT_WIDTH-1:0]  prod_cat;
    logic signed [PEXT_WIDTH-1:0] prod_ext;

    // Sign-extend the fields and keep the operand width
    assign md_ext = EXT_WIDTH'(multiplicand_value);
    assign mq_ext = EXT_WIDTH'(multiplier_value);
    assign md_op  = md_ext[OPERAND_WIDTH-1:0];

    // Feed the first step with a cleared accumulator and guarded multiplicand
    assign v[0]   = in_valid;
    assign in_stall = st[0];
    assign acc[0] = '0;
    assign mq[0]  = mq_ext[OPERAND_WIDTH-1:0];
    assign md[0]  = {md_op[OPERAND_WIDTH-1], md_op};
    assign pv[0]  = 1'b0;

    // One stage per Booth step
    for (genvar i = 0; i < OPERAND_WIDTH; i++)
    begin : g_step
        bsm_stage #(
            .OPERAND_WIDTH (OPERAND_WIDTH)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (v[i]),
            .up_stall (st[i]),
            .up_acc   (acc[i]),
            .up_mq    (mq[i]),
            .up_md    (md[i]),
            .up_prev  (pv[i]),
            .dn_valid (v[i+1]),
            .dn_stall (st[i+1]),
            .dn_acc   (acc[i+1]),
            .dn_mq    (mq[i+1]),
            .dn_md    (md[i+1]),
            .dn_prev  (pv[i+1])
        );
    end

    // Join the halves and fit the result to the product field width
    assign st[OPERAND_WIDTH] = out_stall;
    assign out_valid         = v[OPERAND_WIDTH];
    assign prod_cat          = {acc[OPERAND_WIDTH], mq[OPERAND_WIDTH]};
    assign prod_ext          = PEXT_WIDTH'(prod_cat);
    assign product_value     = prod_ext[PRODUCT_WIDTH-1:0];

endmodule

// ----- sv/bsm_checker.sv -----
// Port-level checks for the Booth multiplier pipeline, bound to the top level.
// Depends on bsm_pkg and booth_signed_multiplier.
module bsm_checker (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     in_valid,
    input logic                                     in_stall,
    input logic signed [bsm_pkg::FIELD_WIDTH-1:0]   multiplicand_value,
    input logic signed [bsm_pkg::FIELD_WIDTH-1:0]   multiplier_value,
    input logic                                     out_valid,
    input logic                                     out_stall,
    input logic signed [bsm_pkg::PRODUCT_WIDTH-1:0] product_value
);
    import bsm_pkg::*;

    // An empty output stage means every stage can advance
    a_idle_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage is empty");

    // Input stalls only when the output side holds back
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall)
        else $error("input stalled without an output stall");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product_value))
        else $error("stalled result changed or dropped");

endmodule

bind booth_signed_multiplier bsm_checker u_bsm_checker (.*);

// ----- tb/product_scoreboard_pkg.sv -----
// Scoreboard for the signed Booth multiplier: predicts products by Booth recoding
// and checks the results that leave the block, in order.
// Depends on bsm_pkg for the widths and the recoding codes.
package product_scoreboard_pkg;

    import bsm_pkg::*;

    class product_scoreboard;

        logic signed [PRODUCT_WIDTH-1:0] pending_products[$];
        int mismatches;
        int products_checked;
        int operands_noted;

        function new();
            mismatches       = 0;
            products_checked = 0;
            operands_noted   = 0;
        endfunction

        // Recode the multiplier bit pair by bit pair over a guarded accumulator
        static function logic signed [PRODUCT_WIDTH-1:0] booth_product(
            logic signed [FIELD_WIDTH-1:0] mcand,
            logic signed [FIELD_WIDTH-1:0] mplier
        );
            logic [FIELD_WIDTH:0]   acc;
            logic [FIELD_WIDTH:0]   mcand_ext;
            logic [FIELD_WIDTH-1:0] mq;
            logic                   prev_bit;
            booth_op_t              op;
            acc       = '0;
            mcand_ext = {mcand[FIELD_WIDTH-1], mcand};
            mq        = mplier;
            prev_bit  = 1'b0;
            for (int step = 0; step < FIELD_WIDTH; step++)
            begin
                op = booth_op_t'({mq[0], prev_bit});
                case (op)
                    BOOTH_SUB: acc = acc + ~mcand_ext + 1'b1;
                    BOOTH_ADD: acc = acc + mcand_ext;
                    default:   acc = acc;
                endcase
                // Shift {acc, mq, prev} right arithmetically
                prev_bit = mq[0];
                mq       = {acc[0], mq[FIELD_WIDTH-1:1]};
                acc      = {acc[FIELD_WIDTH], acc[FIELD_WIDTH:1]};
            end
            return {acc[FIELD_WIDTH-1:0], mq};
        endfunction

        // Queue the product expected for an accepted operand pair
        function void note_operands(logic signed [FIELD_WIDTH-1:0] mcand,
                                    logic signed [FIELD_WIDTH-1:0] mplier);
            pending_products.push_back(booth_product(mcand, mplier));
            operands_noted++;
        endfunction

        // Compare a product leaving the block with the oldest expectation
        function void check_product(logic signed [PRODUCT_WIDTH-1:0] actual);
            logic signed [PRODUCT_WIDTH-1:0] expected;
            if (pending_products.size() == 0)
            begin
                $error("product_value: no item expected, actual %0d", actual);
                mismatches++;
            end
            else
            begin
                expected = pending_products.pop_front();
                products_checked++;
                if (actual !== expected)
                begin
                    $error("product_value: expected %0d, actual %0d", expected, actual);
                    mismatches++;
                end
            end
        endfunction

    endclass

endpackage

// ----- tb/booth_signed_multiplier_tb.sv -----
// Top of the testbench for the signed Booth multiplier: drives operand pairs
// with random gaps and output stalls, checks every product in order.
// Depends on bsm_pkg, product_scoreboard_pkg and booth_signed_multiplier.
module booth_signed_multiplier_tb;

    import bsm_pkg::*;
    import product_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS   = 750;
    localparam int STEADY_FIRST   = 300;
    localparam int STEADY_LAST    = 480;
    localparam int IDLE_PERCENT   = 19;
    localparam int PIPE_LATENCY   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIRECTED_ITEMS = 20;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic signed [FIELD_WIDTH-1:0]   multiplicand_value;
    logic signed [FIELD_WIDTH-1:0]   multiplier_value;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [PRODUCT_WIDTH-1:0] product_value;

    logic steady_phase;
    int   quiet_cycles;

    product_scoreboard products = new();

    booth_signed_multiplier i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .multiplicand_value (multiplicand_value),
        .multiplier_value   (multiplier_value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .product_value      (product_value)
    );

    // Free-running clock, period 2
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Present one operand pair, hold it until accepted
    task automatic send_operands(input logic signed [FIELD_WIDTH-1:0] mcand,
                                 input logic signed [FIELD_WIDTH-1:0] mplier);
        while (!steady_phase && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        multiplicand_value <= mcand;
        multiplier_value   <= mplier;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Pick a field value, biased toward the extremes now and then
    function automatic logic signed [FIELD_WIDTH-1:0] pick_operand();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return {FIELD_WIDTH{$urandom_range(1) == 1}};
            3:       return 16'sh0001;
            default: return FIELD_WIDTH'($urandom);
        endcase
    endfunction

    // Stall the output at random outside the steady stretch
    always @(posedge clk)
    begin
        out_stall <= !steady_phase && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Watch both handshakes, feed the scoreboard, guard against hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                products.note_operands(multiplicand_value, multiplier_value);
            if (out_valid && !out_stall)
                products.check_product(product_value);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        else
            quiet_cycles <= 0;
    end

    initial
    begin
        logic signed [FIELD_WIDTH-1:0] directed_mcand [DIRECTED_ITEMS];
        logic signed [FIELD_WIDTH-1:0] directed_mplier[DIRECTED_ITEMS];
        // Extremes, zero, unit values and alternating bit patterns that
        // force an add or subtract on every Booth step after the first
        directed_mcand  = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000,
                            16'sh1234, 16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh8000,
                            16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sh0001,
                            16'sh0003, 16'shFFFE, 16'sh4000, 16'sh8001, 16'sh00FF};
        directed_mplier = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                            16'sh0000, 16'shFFFF, 16'shFFFF, 16'sh0001, 16'sh0001,
                            16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 16'sh8000,
                            16'shFFFE, 16'sh0003, 16'sh4000, 16'sh8001, 16'shFF00};

        rst_n              <= 1'b0;
        in_valid           <= 1'b0;
        multiplicand_value <= '0;
        multiplier_value   <= '0;
        steady_phase       <= 1'b0;

        // Hold reset low before releasing it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs
        for (int idx = 0; idx < DIRECTED_ITEMS; idx++)
            send_operands(directed_mcand[idx], directed_mplier[idx]);

        // Random pairs with one long stretch free of gaps and stalls
        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            if (idx == STEADY_FIRST)
                steady_phase <= 1'b1;
            else if (idx == STEADY_LAST)
                steady_phase <= 1'b0;
            send_operands(pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;

        // Drain the pipeline, then look for stray items
        while (products.pending_products.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("Covered %0d operand pairs (%0d directed at the extremes), %0d products checked.",
                 products.operands_noted, DIRECTED_ITEMS, products.products_checked);
        if (products.mismatches == 0 && products.pending_products.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
